// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`endif

// ===== rtl/core/cst_pkg.sv =====
// ----------------------------------------------------------------------------
// cst_pkg
// Shared constants, types and classification functions of the tokenizer.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int KIND_BITS = 6;
  localparam int LEN_BITS = 16;
  localparam int START_BITS = 16;

  localparam logic [KIND_BITS-1:0] K_END   = 6'd0;
  localparam logic [KIND_BITS-1:0] K_ID    = 6'd1;
  localparam logic [KIND_BITS-1:0] K_NUM   = 6'd2;
  localparam logic [KIND_BITS-1:0] K_STR   = 6'd3;
  localparam logic [KIND_BITS-1:0] K_RET   = 6'd4;
  localparam logic [KIND_BITS-1:0] K_INT   = 6'd5;
  localparam logic [KIND_BITS-1:0] K_LONG  = 6'd6;
  localparam logic [KIND_BITS-1:0] K_VOID  = 6'd7;
  localparam logic [KIND_BITS-1:0] K_NONE  = 6'd0;
  localparam logic [KIND_BITS-1:0] K_ERROR = 6'd41;

  localparam logic [3:0] M_IDLE       = 4'd0;
  localparam logic [3:0] M_IDENT      = 4'd1;
  localparam logic [3:0] M_ZERO       = 4'd2;
  localparam logic [3:0] M_NUMBER     = 4'd3;
  localparam logic [3:0] M_HEX        = 4'd4;
  localparam logic [3:0] M_STRING     = 4'd5;
  localparam logic [3:0] M_OP         = 4'd6;
  localparam logic [3:0] M_LINE       = 4'd7;
  localparam logic [3:0] M_BLOCK      = 4'd8;
  localparam logic [3:0] M_BLOCK_STAR = 4'd9;
  localparam logic [3:0] M_HALTED     = 4'd10;

  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  localparam logic [47:0] W_RETURN = 48'h72657475726E;
  localparam logic [47:0] W_INT    = 48'h696E74;
  localparam logic [47:0] W_LONG   = 48'h6C6F6E67;
  localparam logic [47:0] W_VOID   = 48'h766F6964;

  // One token on its way from the scanner to the output queue.
  typedef struct packed {
    logic [KIND_BITS-1:0]  kind;
    logic [START_BITS-1:0] start;
    logic [LEN_BITS-1:0]   length;
    logic                  last;
  } token_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_xdigit(input logic [7:0] c);
    return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [KIND_BITS-1:0] plain_punct(input logic [7:0] c);
    case (c)
      8'h28: return 6'd8;
      8'h29: return 6'd9;
      8'h7B: return 6'd10;
      8'h7D: return 6'd11;
      8'h3A: return 6'd12;
      8'h2C: return 6'd13;
      8'h3B: return 6'd14;
      8'h5B: return 6'd15;
      8'h5D: return 6'd16;
      default: return K_NONE;
    endcase
  endfunction

  function automatic logic [KIND_BITS-1:0] op_single(input logic [7:0] c);
    case (c)
      8'h3D: return 6'd17;
      8'h2B: return 6'd21;
      8'h2D: return 6'd24;
      8'h21: return 6'd26;
      8'h5E: return 6'd28;
      8'h2F: return 6'd30;
      8'h2A: return 6'd32;
      8'h25: return 6'd34;
      8'h3C: return 6'd37;
      8'h3E: return 6'd40;
      default: return K_NONE;
    endcase
  endfunction

  function automatic logic [KIND_BITS-1:0] op_pair(input logic [7:0] a, input logic [7:0] b);
    logic [KIND_BITS-1:0] k;
    k = K_NONE;
    if (b == 8'h3D) begin
      case (a)
        8'h3D: k = 6'd18;
        8'h2B: k = 6'd20;
        8'h2D: k = 6'd23;
        8'h21: k = 6'd25;
        8'h5E: k = 6'd27;
        8'h2F: k = 6'd29;
        8'h2A: k = 6'd31;
        8'h25: k = 6'd33;
        8'h3C: k = 6'd35;
        8'h3E: k = 6'd38;
        default: k = K_NONE;
      endcase
    end else if (a == b) begin
      case (a)
        8'h2B: k = 6'd19;
        8'h2D: k = 6'd22;
        8'h3C: k = 6'd36;
        8'h3E: k = 6'd39;
        default: k = K_NONE;
      endcase
    end
    return k;
  endfunction

  function automatic logic [LEN_BITS-1:0] sat_inc(input logic [LEN_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

endpackage

// ===== rtl/core/cst_stream_if.sv =====
// ----------------------------------------------------------------------------
// cst_stream_if
// Valid/ready channel carrying one payload word of a given type.
// ----------------------------------------------------------------------------
interface cst_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/cst_in_if.sv =====
// ----------------------------------------------------------------------------
// cst_in_if
// Input channel of the tokenizer: one text byte or the end marker per word.
// ----------------------------------------------------------------------------
interface cst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

// ===== rtl/core/cst_out_if.sv =====
// ----------------------------------------------------------------------------
// cst_out_if
// Output channel of the tokenizer: one token per word.
// ----------------------------------------------------------------------------
interface cst_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic        last_of_run;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input token_start,
                input token_length, input last_of_run, output ready);
endinterface

// ===== rtl/core/cst_scan.sv =====
// ----------------------------------------------------------------------------
// cst_scan
// Front part: steps the scan state on each accepted word and produces up to
// two tokens in that cycle.
// ----------------------------------------------------------------------------
module cst_scan #(
  parameter int POSITION_BITS = cst_pkg::POSITION_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic [7:0]     text_byte,
  input  logic           end_of_text,
  output logic [1:0]     count,
  output cst_pkg::token_t tok0,
  output cst_pkg::token_t tok1
);

  logic [3:0]               scan_mode, scan_mode_next;
  logic [7:0]               pending_char, pending_char_next;
  logic [POSITION_BITS-1:0] byte_position, byte_position_next;
  logic [POSITION_BITS-1:0] start_position, start_position_next;
  logic [15:0]              run_length, run_length_next;
  logic [47:0]              word_prefix, word_prefix_next;

  logic [5:0]  id_kind;
  logic [15:0] cur_start, pos16;
  logic        go_idle;
  logic [5:0]  k;

  always_comb begin
    id_kind = cst_pkg::K_ID;
    if (run_length == 16'd6 && word_prefix == cst_pkg::W_RETURN) id_kind = cst_pkg::K_RET;
    else if (run_length == 16'd3 && word_prefix == cst_pkg::W_INT) id_kind = cst_pkg::K_INT;
    else if (run_length == 16'd4 && word_prefix == cst_pkg::W_LONG) id_kind = cst_pkg::K_LONG;
    else if (run_length == 16'd4 && word_prefix == cst_pkg::W_VOID) id_kind = cst_pkg::K_VOID;
  end

  // Reported offsets are the low 16 bits of the position counters, widened
  // with zeros when the counters are narrower.
  assign cur_start = 16'(start_position);
  assign pos16 = 16'(byte_position);

  always_comb begin
    scan_mode_next      = scan_mode;
    pending_char_next   = pending_char;
    byte_position_next  = byte_position;
    start_position_next = start_position;
    run_length_next     = run_length;
    word_prefix_next    = word_prefix;
    count = 2'd0;
    tok0  = '0;
    tok1  = '0;
    go_idle = 1'b0;
    k = cst_pkg::op_pair(pending_char, text_byte);
    if (scan_mode == cst_pkg::M_HALTED) begin
      go_idle = 1'b0;
    end else if (end_of_text) begin
      case (scan_mode)
        cst_pkg::M_IDENT: begin
          tok0 = '{id_kind, cur_start, run_length, 1'b0};
          count = 2'd1;
        end
        cst_pkg::M_ZERO, cst_pkg::M_NUMBER, cst_pkg::M_HEX: begin
          tok0 = '{cst_pkg::K_NUM, cur_start, run_length, 1'b0};
          count = 2'd1;
        end
        cst_pkg::M_OP: begin
          tok0 = '{cst_pkg::op_single(pending_char), cur_start, 16'd1, 1'b0};
          count = 2'd1;
        end
        default: count = 2'd0;
      endcase
      if (scan_mode == cst_pkg::M_STRING) begin
        tok0 = '{cst_pkg::K_ERROR, cur_start, run_length, 1'b1};
        count = 2'd1;
        scan_mode_next = cst_pkg::M_HALTED;
      end else begin
        if (count == 2'd1) tok1 = '{cst_pkg::K_END, pos16, 16'd0, 1'b1};
        else tok0 = '{cst_pkg::K_END, pos16, 16'd0, 1'b1};
        count = count + 2'd1;
        scan_mode_next      = cst_pkg::M_IDLE;
        pending_char_next   = '0;
        byte_position_next  = '0;
        start_position_next = '0;
        run_length_next     = '0;
        word_prefix_next    = '0;
      end
    end else begin
      byte_position_next = byte_position + 1'b1;
      case (scan_mode)
        cst_pkg::M_IDENT: begin
          if (cst_pkg::is_alpha(text_byte) || cst_pkg::is_digit(text_byte) ||
              text_byte == cst_pkg::CH_UNDER) begin
            if (run_length < 16'd6) word_prefix_next = {word_prefix[39:0], text_byte};
            run_length_next = cst_pkg::sat_inc(run_length);
          end else begin
            tok0 = '{id_kind, cur_start, run_length, 1'b0};
            count = 2'd1;
            go_idle = 1'b1;
          end
        end
        cst_pkg::M_ZERO: begin
          if (text_byte == cst_pkg::CH_X) begin
            scan_mode_next = cst_pkg::M_HEX;
            run_length_next = 16'd2;
          end else if (cst_pkg::is_digit(text_byte)) begin
            scan_mode_next = cst_pkg::M_NUMBER;
            run_length_next = 16'd2;
          end else begin
            tok0 = '{cst_pkg::K_NUM, cur_start, run_length, 1'b0};
            count = 2'd1;
            go_idle = 1'b1;
          end
        end
        cst_pkg::M_NUMBER, cst_pkg::M_HEX: begin
          if ((scan_mode == cst_pkg::M_NUMBER) ? cst_pkg::is_digit(text_byte)
                                               : cst_pkg::is_xdigit(text_byte)) begin
            run_length_next = cst_pkg::sat_inc(run_length);
          end else begin
            tok0 = '{cst_pkg::K_NUM, cur_start, run_length, 1'b0};
            count = 2'd1;
            go_idle = 1'b1;
          end
        end
        cst_pkg::M_STRING: begin
          if (text_byte == cst_pkg::CH_QUOTE) begin
            tok0 = '{cst_pkg::K_STR, cur_start, run_length, 1'b1};
            count = 2'd1;
            scan_mode_next = cst_pkg::M_IDLE;
          end else begin
            run_length_next = cst_pkg::sat_inc(run_length);
          end
        end
        cst_pkg::M_OP: begin
          if (pending_char == cst_pkg::CH_SLASH && text_byte == cst_pkg::CH_SLASH) begin
            scan_mode_next = cst_pkg::M_LINE;
          end else if (pending_char == cst_pkg::CH_SLASH && text_byte == cst_pkg::CH_STAR) begin
            scan_mode_next = cst_pkg::M_BLOCK;
          end else if (k != cst_pkg::K_NONE) begin
            tok0 = '{k, cur_start, 16'd2, 1'b1};
            count = 2'd1;
            scan_mode_next = cst_pkg::M_IDLE;
          end else begin
            tok0 = '{cst_pkg::op_single(pending_char), cur_start, 16'd1, 1'b0};
            count = 2'd1;
            go_idle = 1'b1;
          end
        end
        cst_pkg::M_LINE: begin
          if (text_byte == cst_pkg::CH_NL) scan_mode_next = cst_pkg::M_IDLE;
        end
        cst_pkg::M_BLOCK: begin
          if (text_byte == cst_pkg::CH_STAR) scan_mode_next = cst_pkg::M_BLOCK_STAR;
        end
        cst_pkg::M_BLOCK_STAR: begin
          if (text_byte == cst_pkg::CH_SLASH) scan_mode_next = cst_pkg::M_IDLE;
          else if (text_byte != cst_pkg::CH_STAR) scan_mode_next = cst_pkg::M_BLOCK;
        end
        default: go_idle = 1'b1;
      endcase
      if (go_idle) begin
        scan_mode_next = cst_pkg::M_IDLE;
        if (text_byte inside {8'h20, 8'h09, 8'h0D, 8'h0A}) begin
          scan_mode_next = cst_pkg::M_IDLE;
        end else if (cst_pkg::is_alpha(text_byte) || text_byte == cst_pkg::CH_UNDER) begin
          scan_mode_next = cst_pkg::M_IDENT;
          start_position_next = byte_position;
          run_length_next = 16'd1;
          word_prefix_next = {40'd0, text_byte};
        end else if (text_byte == 8'h30) begin
          scan_mode_next = cst_pkg::M_ZERO;
          start_position_next = byte_position;
          run_length_next = 16'd1;
        end else if (cst_pkg::is_digit(text_byte)) begin
          scan_mode_next = cst_pkg::M_NUMBER;
          start_position_next = byte_position;
          run_length_next = 16'd1;
        end else if (text_byte == cst_pkg::CH_QUOTE) begin
          scan_mode_next = cst_pkg::M_STRING;
          start_position_next = byte_position;
          run_length_next = 16'd0;
        end else if (cst_pkg::plain_punct(text_byte) != cst_pkg::K_NONE) begin
          if (count == 2'd1) tok1 = '{cst_pkg::plain_punct(text_byte), pos16, 16'd1, 1'b0};
          else tok0 = '{cst_pkg::plain_punct(text_byte), pos16, 16'd1, 1'b0};
          count = count + 2'd1;
        end else if (cst_pkg::op_single(text_byte) != cst_pkg::K_NONE) begin
          scan_mode_next = cst_pkg::M_OP;
          start_position_next = byte_position;
          run_length_next = 16'd1;
          pending_char_next = text_byte;
        end else begin
          if (count == 2'd1) tok1 = '{cst_pkg::K_ERROR, pos16, 16'd1, 1'b0};
          else tok0 = '{cst_pkg::K_ERROR, pos16, 16'd1, 1'b0};
          count = count + 2'd1;
          scan_mode_next = cst_pkg::M_HALTED;
        end
        if (count == 2'd2) tok1.last = 1'b1;
        else if (count == 2'd1) tok0.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode      <= cst_pkg::M_IDLE;
      pending_char   <= '0;
      byte_position  <= '0;
      start_position <= '0;
      run_length     <= '0;
      word_prefix    <= '0;
    end else if (step) begin
      scan_mode      <= scan_mode_next;
      pending_char   <= pending_char_next;
      byte_position  <= byte_position_next;
      start_position <= start_position_next;
      run_length     <= run_length_next;
      word_prefix    <= word_prefix_next;
    end
  end

endmodule

// ===== rtl/core/cst_queue.sv =====
// ----------------------------------------------------------------------------
// cst_queue
// Four-entry token queue between scanner and output; takes up to two tokens
// per cycle and hands out one per cycle while the sink is ready.
// ----------------------------------------------------------------------------
module cst_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic [1:0]      push_count,
  input  cst_pkg::token_t push0,
  input  cst_pkg::token_t push1,
  output logic            room_for_two,
  cst_stream_if.source    out
);

  cst_pkg::token_t entry [4];
  logic [1:0] rd_ptr, wr_ptr;
  logic [2:0] fill, fill_next;
  logic       pop;

  assign pop = out.valid && out.ready;
  assign out.valid = fill != 3'd0;
  assign out.data = entry[rd_ptr];
  assign room_for_two = fill <= 3'd2;
  assign fill_next = fill + {1'b0, push_count} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) entry[wr_ptr] <= push0;
    if (push_count == 2'd2) entry[wr_ptr + 2'd1] <= push1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill   <= '0;
    end else begin
      rd_ptr <= rd_ptr + {1'b0, pop};
      wr_ptr <= wr_ptr + push_count;
      fill   <= fill_next;
    end
  end

endmodule

// ===== rtl/core/c_subset_tokenizer.sv =====
// ----------------------------------------------------------------------------
// c_subset_tokenizer
// Streaming tokenizer for a small subset of C source text.
// ----------------------------------------------------------------------------
// The block takes one source byte per word on the input channel and gives
// tokens (kind, start offset, length) on the output channel. It accepts a
// word in every cycle while its four-entry token queue has room for the two
// tokens that one byte may cause, so the sustained rate is one byte per
// cycle whenever the sink takes tokens at least as fast as they are made; a
// token can leave at the earliest in the cycle after its byte is taken. An end
// marker word flushes any pending token and gives the end token, after
// which offsets start again from zero. An unsupported byte or an unclosed
// string gives an error token and the block then ignores all input, still
// taking words, until reset.
module c_subset_tokenizer #(
  parameter int POSITION_BITS = cst_pkg::POSITION_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  cst_in_if.sink   in,
  cst_out_if.source out
);

  cst_stream_if #(.T(cst_pkg::token_t)) q_out ();

  logic            step;
  logic            room;
  logic [1:0]      count;
  cst_pkg::token_t tok0, tok1;

  // Input is held back only when the queue could not take two more tokens.
  assign in.ready = room;
  assign step = in.valid && room;

  cst_scan #(.POSITION_BITS(POSITION_BITS)) u_scan (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .text_byte   (in.text_byte),
    .end_of_text (in.end_of_text),
    .count       (count),
    .tok0        (tok0),
    .tok1        (tok1)
  );

  cst_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .push_count   (step ? count : 2'd0),
    .push0        (tok0),
    .push1        (tok1),
    .room_for_two (room),
    .out          (q_out.source)
  );

  assign out.valid        = q_out.valid;
  assign q_out.ready      = out.ready;
  assign out.token_kind   = q_out.data.kind;
  assign out.token_start  = q_out.data.start;
  assign out.token_length = q_out.data.length;
  assign out.last_of_run  = q_out.data.last;

endmodule

// ===== rtl/core/cst_checker.sv =====
// ----------------------------------------------------------------------------
// cst_checker
// Port-level checks of the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cst_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [5:0]  token_kind,
  input logic [15:0] token_length
);

  `CHK_IMPL(a_end_len, clk, rst, out_valid && token_kind == cst_pkg::K_END, token_length == 16'd0, "end token with nonzero length")
  `CHK_IMPL(a_kind_range, clk, rst, out_valid, token_kind <= cst_pkg::K_ERROR, "token kind out of range")
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "token withdrawn")
  `CHK_NEXT(a_ready_after_drain, clk, rst, !out_valid && !in_valid, in_ready, "input blocked with empty queue")

endmodule

bind c_subset_tokenizer cst_checker u_cst_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in.valid),
  .in_ready     (in.ready),
  .out_valid    (out.valid),
  .out_ready    (out.ready),
  .token_kind   (out.token_kind),
  .token_length (out.token_length)
);

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench of the C subset tokenizer: random well-formed text with
// noise, a token predictor in a small scoreboard class, and random idling.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cst_pkg::*;

  // Operator table: the first byte, its single kind, its kind when followed by
  // '=', and its kind when doubled (zero where doubling means nothing).
  localparam logic [7:0] OP_CHAR [10] = '{8'h3D, 8'h2B, 8'h2D, 8'h21, 8'h5E,
                                          8'h2F, 8'h2A, 8'h25, 8'h3C, 8'h3E};
  localparam int OP_ONE [10] = '{17, 21, 24, 26, 28, 30, 32, 34, 37, 40};
  localparam int OP_EQ  [10] = '{18, 20, 23, 25, 27, 29, 31, 33, 35, 38};
  localparam int OP_DBL [10] = '{0, 19, 22, 0, 0, 0, 0, 0, 36, 39};
  localparam string PUNCT = "(){}:,;[]";
  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam int STALL_LONG = 300;

  // Predicts the tokens of each accepted word and holds them until they come.
  class token_board;
    logic [3:0]  mode;
    logic [7:0]  pend;
    logic [15:0] bpos, spos, rlen;
    logic [47:0] prefix;
    token_t      fresh[$];
    token_t      waiting[$];
    int          fails;

    function new();
      fails = 0;
      clear();
    endfunction

    function void clear();
      mode = M_IDLE; pend = 0; bpos = 0; spos = 0; rlen = 0; prefix = 0;
    endfunction

    function bit letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function int op_index(logic [7:0] c);
      for (int i = 0; i < 10; i++) if (OP_CHAR[i] == c) return i;
      return -1;
    endfunction

    function logic [15:0] bump(logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function logic [5:0] word_kind();
      if (rlen == 6 && prefix == W_RETURN) return K_RET;
      if (rlen == 3 && prefix == W_INT) return K_INT;
      if (rlen == 4 && prefix == W_LONG) return K_LONG;
      if (rlen == 4 && prefix == W_VOID) return K_VOID;
      return K_ID;
    endfunction

    function void emit(int kind, logic [15:0] st, logic [15:0] len);
      token_t t;
      t.kind = kind[5:0]; t.start = st; t.length = len; t.last = 1'b0;
      fresh.push_back(t);
    endfunction

    function void mark_last();
      if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
    endfunction

    // One word through the scanner; the tokens it causes land in fresh.
    function void scan(logic [7:0] c, bit eot);
      logic [15:0] pos;
      int oi, k;
      fresh.delete();
      if (mode == M_HALTED) return;
      if (eot) begin
        case (mode)
          M_IDENT: emit(word_kind(), spos, rlen);
          M_ZERO, M_NUMBER, M_HEX: emit(K_NUM, spos, rlen);
          M_OP: emit(OP_ONE[op_index(pend)], spos, 1);
          M_STRING: begin
            emit(K_ERROR, spos, rlen);
            mark_last();
            mode = M_HALTED;
            return;
          end
          default: ;
        endcase
        emit(K_END, bpos, 0);
        mark_last();
        clear();
        return;
      end
      pos = bpos;
      bpos = bpos + 16'd1;
      case (mode)
        M_IDENT: begin
          if (letter(c) || digit(c) || c == CH_UNDER) begin
            if (rlen < 6) prefix = {prefix[39:0], c};
            rlen = bump(rlen);
            return;
          end
          emit(word_kind(), spos, rlen);
        end
        M_ZERO: begin
          if (c == CH_X) begin mode = M_HEX; rlen = 2; return; end
          if (digit(c)) begin mode = M_NUMBER; rlen = 2; return; end
          emit(K_NUM, spos, rlen);
        end
        M_NUMBER, M_HEX: begin
          if (digit(c) || (mode == M_HEX &&
              ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")))) begin
            rlen = bump(rlen);
            return;
          end
          emit(K_NUM, spos, rlen);
        end
        M_STRING: begin
          if (c == CH_QUOTE) begin
            emit(K_STR, spos, rlen);
            mark_last();
            mode = M_IDLE;
          end else begin
            rlen = bump(rlen);
          end
          return;
        end
        M_OP: begin
          if (pend == CH_SLASH && c == CH_SLASH) begin mode = M_LINE; return; end
          if (pend == CH_SLASH && c == CH_STAR) begin mode = M_BLOCK; return; end
          oi = op_index(pend);
          k = (c == CH_EQ) ? OP_EQ[oi] : (c == pend) ? OP_DBL[oi] : 0;
          if (k != 0) begin
            emit(k, spos, 2);
            mark_last();
            mode = M_IDLE;
            return;
          end
          emit(OP_ONE[oi], spos, 1);
        end
        M_LINE: begin
          if (c == CH_NL) mode = M_IDLE;
          return;
        end
        M_BLOCK: begin
          if (c == CH_STAR) mode = M_BLOCK_STAR;
          return;
        end
        M_BLOCK_STAR: begin
          if (c == CH_SLASH) mode = M_IDLE;
          else if (c != CH_STAR) mode = M_BLOCK;
          return;
        end
        default: ;
      endcase
      mode = M_IDLE;
      // Between tokens: this byte opens something new.
      k = 0;
      for (int i = 0; i < PUNCT.len(); i++) if (PUNCT[i] == c) k = 8 + i;
      oi = op_index(c);
      if (c == " " || c == 8'h09 || c == 8'h0D || c == CH_NL) begin
      end else if (letter(c) || c == CH_UNDER) begin
        mode = M_IDENT; spos = pos; rlen = 1; prefix = {40'd0, c};
      end else if (c == "0") begin
        mode = M_ZERO; spos = pos; rlen = 1;
      end else if (digit(c)) begin
        mode = M_NUMBER; spos = pos; rlen = 1;
      end else if (c == CH_QUOTE) begin
        mode = M_STRING; spos = pos; rlen = 0;
      end else if (k != 0) begin
        emit(k, pos, 1);
      end else if (oi >= 0) begin
        mode = M_OP; spos = pos; rlen = 1; pend = c;
      end else begin
        emit(K_ERROR, pos, 1);
        mode = M_HALTED;
      end
      mark_last();
    endfunction

    // Dry run: would this word stop the block for good?
    function bit would_halt(logic [7:0] c, bit eot);
      logic [3:0] m0; logic [7:0] p0; logic [15:0] b0, s0, r0; logic [47:0] w0;
      bit hit;
      m0 = mode; p0 = pend; b0 = bpos; s0 = spos; r0 = rlen; w0 = prefix;
      scan(c, eot);
      hit = (mode == M_HALTED) && (m0 != M_HALTED);
      mode = m0; pend = p0; bpos = b0; spos = s0; rlen = r0; prefix = w0;
      return hit;
    endfunction

    function void note_word(logic [7:0] c, bit eot);
      scan(c, eot);
      foreach (fresh[i]) waiting.push_back(fresh[i]);
    endfunction

    function void check_token(token_t got);
      token_t want;
      if (waiting.size() == 0) begin
        $display("%0t: token with none expected, got kind %0d start %0d len %0d",
                 $time, got.kind, got.start, got.length);
        fails++;
        return;
      end
      want = waiting.pop_front();
      if (want.kind != got.kind) begin
        $display("%0t: kind expected %0d, got %0d", $time, want.kind, got.kind);
        fails++;
      end
      if (want.start != got.start) begin
        $display("%0t: start expected %0d, got %0d", $time, want.start, got.start);
        fails++;
      end
      if (want.length != got.length) begin
        $display("%0t: length expected %0d, got %0d", $time, want.length, got.length);
        fails++;
      end
      if (want.last != got.last) begin
        $display("%0t: last_of_run expected %0d, got %0d", $time, want.last, got.last);
        fails++;
      end
    endfunction

    function int pending();
      return waiting.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  cst_in_if  in_ch ();
  cst_out_if out_ch ();
  token_board sb = new();

  int send_idle = 0;     // sender idle chance per hundred
  int recv_idle = 0;     // receiver idle chance per hundred
  int stall_left = 0;    // long receiver hold-off, counted down below
  bit halt_ok = 1'b0;    // only the closing words may stop the block
  int words = 0;

  c_subset_tokenizer u_dut (
    .clk (clk),
    .rst (rst),
    .in  (in_ch),
    .out (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random idling, plus the long hold-off when one is asked for.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Every signal is stable between the falling and the rising edge, so a
  // token seen here with valid and ready high is taken at the next edge.
  always @(negedge clk) begin
    token_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.kind = out_ch.token_kind;
      got.start = out_ch.token_start;
      got.length = out_ch.token_length;
      got.last = out_ch.last_of_run;
      sb.check_token(got);
    end
  end

  // Offers one word and returns at the edge where it is taken.
  task automatic offer(logic [7:0] c, bit eot);
    bit rdy;
    while ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.text_byte <= c;
    in_ch.end_of_text <= eot;
    do begin
      @(negedge clk);
      rdy = in_ch.ready;
      @(posedge clk);
    end while (!rdy);
    sb.note_word(c, eot);
    words++;
  endtask

  // Sends a word, but steers round anything that would halt the block too
  // early: an end marker inside a string gets its closing quote first, and
  // a stray byte between tokens becomes a space.
  task automatic put_word(logic [7:0] c, bit eot);
    if (!halt_ok && sb.would_halt(c, eot)) begin
      if (eot) offer(CH_QUOTE, 1'b0);
      else c = " ";
    end
    offer(c, eot);
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put_word(s[i], 1'b0);
  endtask

  task automatic put_end();
    put_word($urandom_range(0, 255), 1'b1);
  endtask

  function automatic logic [7:0] word_char(bit first);
    int r;
    r = $urandom_range(0, first ? 52 : 62);
    if (r < 26) return "a" + r;
    if (r < 52) return "A" + r - 26;
    if (r == 52) return CH_UNDER;
    return "0" + r - 53;
  endfunction

  // One random piece of text, mostly well formed.
  task automatic put_piece();
    int n, i;
    logic [7:0] c;
    string kw [8] = '{"return", "int", "long", "void", "returns", "in", "voi", "lon"};
    case ($urandom_range(0, 13))
      0, 1: begin
        n = $urandom_range(1, 9);
        for (i = 0; i < n; i++) put_word(word_char(i == 0), 1'b0);
      end
      2: put_text(kw[$urandom_range(0, 7)]);
      3: begin
        put_word("0", 1'b0);
        if ($urandom_range(0, 1)) put_word(CH_X, 1'b0);
        n = $urandom_range(0, 4);
        for (i = 0; i < n; i++) begin
          c = $urandom_range(0, 2) == 0 ? "a" + $urandom_range(0, 6)
                                        : "0" + $urandom_range(0, 9);
          put_word($urandom_range(0, 3) == 0 ? c - 8'h20 : c, 1'b0);
        end
      end
      4: begin
        n = $urandom_range(1, 5);
        for (i = 0; i < n; i++) put_word("0" + $urandom_range(0, 9), 1'b0);
      end
      5: begin
        put_word(CH_QUOTE, 1'b0);
        n = $urandom_range(0, 6);
        for (i = 0; i < n; i++) begin
          c = $urandom_range(0, 255);
          put_word(c == CH_QUOTE ? 8'h80 : c, 1'b0);
        end
        put_word(CH_QUOTE, 1'b0);
      end
      6, 7: begin
        i = $urandom_range(0, 9);
        put_word(OP_CHAR[i], 1'b0);
        case ($urandom_range(0, 2))
          0: put_word(CH_EQ, 1'b0);
          1: put_word(OP_CHAR[i], 1'b0);
          default: ;
        endcase
      end
      8: put_word(PUNCT[$urandom_range(0, 8)], 1'b0);
      9: begin
        c = $urandom_range(0, 3);
        put_word(c == 0 ? " " : c == 1 ? 8'h09 : c == 2 ? 8'h0D : CH_NL, 1'b0);
      end
      10: begin
        put_text("//");
        n = $urandom_range(0, 6);
        for (i = 0; i < n; i++) begin
          c = $urandom_range(0, 255);
          put_word(c == CH_NL ? "x" : c, 1'b0);
        end
        put_word(CH_NL, 1'b0);
      end
      11: begin
        put_text($urandom_range(0, 2) == 0 ? "/*/" : "/*");
        n = $urandom_range(0, 6);
        for (i = 0; i < n; i++) put_word($urandom_range(0, 255), 1'b0);
        put_text($urandom_range(0, 1) ? "*/" : "**/");
      end
      12: put_word($urandom_range(0, 255), 1'b0);
      default: put_end();
    endcase
  endtask

  // Holds the sender off until every token is in.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.text_byte <= 8'h00;
    in_ch.end_of_text <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_idle = 15;
    recv_idle = 54;
    // Keywords, a bare hex prefix, an empty string, a comment that the
    // star-slash trap must not close, then the awkward operator pairs.
    put_text("return void 0x \"\"/*/*/>=%=>>");
    put_end();
    put_word(8'hFF, 1'b1);

    words = 0;
    for (int i = 0; i < 1550; i = words) begin
      if (i > 1000) begin
        send_idle = 0;
        recv_idle = 0;
      end else if (i > 500) begin
        send_idle = 54;
        recv_idle = 15;
      end else begin
        send_idle = 15;
        recv_idle = 54;
      end
      if (i > 300 && i < 320 && stall_left == 0) stall_left = STALL_LONG;
      if (i > 700 && i < 705) wait_drained();
      put_piece();
    end

    // The run closes on one of the two halting cases, then idle words that
    // the block must ignore.
    put_end();
    halt_ok = 1'b1;
    if ($urandom_range(0, 1)) begin
      put_text("ab \"q");
      put_end();
    end else begin
      put_text("x ");
      put_word(8'h80 + $urandom_range(0, 127), 1'b0);
    end
    repeat (4) put_word($urandom_range(0, 255), $urandom_range(0, 1));
    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("c_subset_tokenizer: match");
    end else begin
      $display("c_subset_tokenizer: mismatch");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("c_subset_tokenizer: mismatch");
    $finish;
  end

endmodule
